// ===== hdl/kgd_pkg.sv =====
// ============================================================================
// kgd_pkg
// Shared types, codes and helpers for the key gesture detector.
// ============================================================================
package kgd_pkg;

  localparam int TIME_W   = 48;             // timestamp width
  localparam int LIM_W    = 16;             // threshold width
  localparam int ELAPSE_W = TIME_W + 1;     // exact signed elapsed time
  localparam int TOUT_W   = LIM_W + 1;      // signed timeout field
  localparam int IN_DATA_W  = 56;           // key_value + now_ms, byte padded
  localparam int OUT_DATA_W = 24;           // action + timeout_ms, byte padded

  localparam logic [LIM_W-1:0] LONG_PRESS_RESET   = 16'd1000;
  localparam logic [LIM_W-1:0] DOUBLE_WINDOW_RESET = 16'd350;

  typedef enum logic {
    OP_KEY   = 1'b0,
    OP_CHECK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KEY_RELEASE = 2'd0,
    KEY_PRESS   = 2'd1,
    KEY_REPEAT  = 2'd2,
    KEY_OTHER   = 2'd3
  } key_t;

  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_CLICK  = 2'd1,
    GEST_LONG   = 2'd2,
    GEST_DOUBLE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CFG_DBL_ENABLE       = 2'd0,
    CFG_LONG_PRESS_MS    = 2'd1,
    CFG_DOUBLE_WINDOW_MS = 2'd2,
    CFG_UNUSED           = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic             dbl_enable;
    logic [LIM_W-1:0] long_press_ms;
    logic [LIM_W-1:0] double_window_ms;
  } cfg_t;

  typedef struct packed {
    op_t               op;
    key_t              key_value;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    action_t                  action;
    logic signed [TOUT_W-1:0] timeout_ms;
  } result_t;

  // Time left until a limit, clamped to 0..65535.
  function automatic logic [LIM_W-1:0] remaining(input logic signed [ELAPSE_W-1:0] el,
                                                 input logic [LIM_W-1:0] limit);
    logic signed [ELAPSE_W:0] diff;
    diff = $signed({{(ELAPSE_W+1-LIM_W){1'b0}}, limit}) - {el[ELAPSE_W-1], el};
    if (diff < 0) begin
      remaining = '0;
    end else if (diff > $signed({{(ELAPSE_W+1-LIM_W){1'b0}}, {LIM_W{1'b1}}})) begin
      remaining = '1;
    end else begin
      remaining = diff[LIM_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/key_gesture_detector_top.sv =====
// ============================================================================
// key_gesture_detector_top
// One-key gesture classifier: click, long press and double click.
// ============================================================================
// Each input transaction is a key event (press, release, autorepeat) or a
// time check, stamped with a 48-bit millisecond time. Every input transaction
// yields exactly one output transaction: an action code and the milliseconds
// until the host should send the next time check (-1 when nothing is
// pending). A time check reports at most one due action; the host repeats it
// until the action comes back as none.
// Throughput is one transaction per clock while the output is not stalled.
// The item is captured in an input register, classified against the gesture
// state (state updates in that same cycle), and the result lands in an
// output register. The only work per item is two 49-bit elapsed-time
// subtracts, their compares and a clamp, so consecutive items need no gaps.
// Back pressure on the output stalls the input register in place; the input takes a
// new transaction whenever it is empty or the output register is free or draining.
// Configuration writes are always accepted (cfg_ready is tied high) and
// should be issued only while no transaction is in flight.
// ============================================================================
module key_gesture_detector_top import kgd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [1:0] key_value, [49:2] now_ms, rest 0
  input  logic                  s_axis_tuser,   // [0] op
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [1:0] action, [18:2] timeout_ms, rest 0
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [LIM_W-1:0]      cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t res, out_res;
  logic    out_valid;
  logic    out_load;   // output register can take a result this cycle
  logic    commit;     // item in the input register is classified now

  assign cfg_ready = 1'b1;

  kgd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign out_load      = !out_valid || m_axis_tready;
  assign commit        = in_valid && out_load;
  assign s_axis_tready = !in_valid || out_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.op        <= op_t'(s_axis_tuser);
      in_item.key_value <= key_t'(s_axis_tdata[1:0]);
      in_item.now_ms    <= s_axis_tdata[TIME_W+1:2];
    end
  end

  kgd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .commit (commit),
    .item   (in_item),
    .cfg    (cfg),
    .res    (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W-2-TOUT_W){1'b0}}, out_res.timeout_ms, out_res.action};

endmodule

// ===== hdl/kgd_cfg.sv =====
// ============================================================================
// kgd_cfg
// Configuration register file written through the config channel.
// ============================================================================
module kgd_cfg import kgd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [LIM_W-1:0]    wr_data,
  output cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dbl_enable       <= 1'b0;
      cfg.long_press_ms    <= LONG_PRESS_RESET;
      cfg.double_window_ms <= DOUBLE_WINDOW_RESET;
    end else if (wr_en) begin
      case (cfg_index_t'(wr_index))
        CFG_DBL_ENABLE:       cfg.dbl_enable       <= wr_data[0];
        CFG_LONG_PRESS_MS:    cfg.long_press_ms    <= wr_data;
        CFG_DOUBLE_WINDOW_MS: cfg.double_window_ms <= wr_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

// ===== hdl/kgd_core.sv =====
// ============================================================================
// kgd_core
// Gesture state registers and the per-item classification logic.
// ============================================================================
module kgd_core import kgd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    commit,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic              key_down, key_down_next;
  logic              long_reported, long_reported_next;
  logic              click_pending, click_pending_next;
  logic [TIME_W-1:0] press_time, press_time_next;
  logic [TIME_W-1:0] first_release_time, first_release_time_next;

  logic signed [ELAPSE_W-1:0] el_press, el_release;
  logic signed [ELAPSE_W-1:0] long_lim, win_lim;
  logic                       long_due, window_due, in_window;
  logic [LIM_W-1:0]           rem_press, rem_release, rem_c, rem_l;
  logic                       press_set, release_set;
  action_t                    act;

  // Elapsed times against the old state, exact and signed.
  assign el_press   = $signed({1'b0, item.now_ms}) - $signed({1'b0, press_time});
  assign el_release = $signed({1'b0, item.now_ms}) - $signed({1'b0, first_release_time});
  assign long_lim   = $signed({{(ELAPSE_W-LIM_W){1'b0}}, cfg.long_press_ms});
  assign win_lim    = $signed({{(ELAPSE_W-LIM_W){1'b0}}, cfg.double_window_ms});

  assign long_due   = el_press >= long_lim;
  assign window_due = el_release >= win_lim;
  assign in_window  = (el_release >= 0) && (el_release <= win_lim);

  assign rem_press   = remaining(el_press, cfg.long_press_ms);
  assign rem_release = remaining(el_release, cfg.double_window_ms);

  always_comb begin
    key_down_next           = key_down;
    long_reported_next      = long_reported;
    click_pending_next      = click_pending;
    press_time_next         = press_time;
    first_release_time_next = first_release_time;
    press_set               = 1'b0;
    release_set             = 1'b0;
    act                     = GEST_NONE;

    if (item.op == OP_CHECK) begin
      if (click_pending && window_due) begin
        click_pending_next = 1'b0;
        act                = GEST_CLICK;
      end else if (key_down && !long_reported && long_due) begin
        long_reported_next = 1'b1;
        act                = GEST_LONG;
      end
    end else begin
      case (item.key_value)
        KEY_PRESS: begin
          if (!key_down) begin
            key_down_next      = 1'b1;
            long_reported_next = 1'b0;
            press_time_next    = item.now_ms;
            press_set          = 1'b1;
          end
        end
        KEY_RELEASE: begin
          if (key_down) begin
            key_down_next = 1'b0;
            if (!long_reported && long_due) begin
              long_reported_next = 1'b1;
              act                = GEST_LONG;
            end else if (long_reported) begin
              act = GEST_NONE;
            end else if (!cfg.dbl_enable) begin
              click_pending_next = 1'b0;
              act                = GEST_CLICK;
            end else if (click_pending && in_window) begin
              click_pending_next = 1'b0;
              act                = GEST_DOUBLE;
            end else begin
              first_release_time_next = item.now_ms;
              release_set             = 1'b1;
              if (click_pending) begin
                act = GEST_CLICK;
              end else begin
                click_pending_next = 1'b1;
              end
            end
          end
        end
        default: ;  // autorepeat and unused codes are ignored
      endcase
    end
  end

  // A time just stored equals now, so its remaining time is the full limit.
  assign rem_c = release_set ? cfg.double_window_ms : rem_release;
  assign rem_l = press_set   ? cfg.long_press_ms    : rem_press;

  always_comb begin
    res.action = act;
    if (click_pending_next && key_down_next && !long_reported_next) begin
      res.timeout_ms = $signed({1'b0, (rem_l < rem_c) ? rem_l : rem_c});
    end else if (click_pending_next) begin
      res.timeout_ms = $signed({1'b0, rem_c});
    end else if (key_down_next && !long_reported_next) begin
      res.timeout_ms = $signed({1'b0, rem_l});
    end else begin
      res.timeout_ms = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_down      <= 1'b0;
      long_reported <= 1'b0;
      click_pending <= 1'b0;
    end else if (commit) begin
      key_down      <= key_down_next;
      long_reported <= long_reported_next;
      click_pending <= click_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      press_time         <= press_time_next;
      first_release_time <= first_release_time_next;
    end
  end

endmodule

// ===== hdl/kgd_checker.sv =====
// ============================================================================
// kgd_checker
// Port-level assertions for the key gesture detector, bound to the top.
// ============================================================================
module kgd_checker import kgd_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // A stalled output transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

  // Nothing leaves the block in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // A negative timeout can only be the "nothing pending" code.
  a_timeout_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[TOUT_W+1] |-> m_axis_tdata[TOUT_W+1:2] == '1)
    else $error("timeout outside -1..65535");

  // Padding above the result fields stays zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:TOUT_W+2] == '0)
    else $error("output padding not zero");

endmodule

bind key_gesture_detector_top kgd_checker u_kgd_checker (.*);
